/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

/* hdl/sbms_pkg.sv */
`default_nettype none
package sbms_pkg;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC
	} state_t;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage
`default_nettype wire

/* hdl/shared_buffer_multi_stack.sv */
// Several LIFO stacks sharing one entry store, with a linked free list.
//
// Request channel: start, req_type, stack_id, push_value. A request is taken
// at a rising edge with start high and busy low. Push (req_type 0) writes
// push_value onto stack stack_id; pop (req_type 1) removes its top entry.
//
// Result channel: pop_value, status, entries_used, marked by done for one
// cycle. Every request gives exactly one result. The receiver cannot stall;
// the result is taken at the edge that ends the done cycle.
//
// Timing: a request taken at an edge addresses the link and value stores in
// its accept cycle, uses their registered read data in EXEC, writes back at
// the edge that ends EXEC and shows its result in the cycle after. busy is
// high for one cycle after each request, so none is taken before write-back;
// the free list and stack tops wait on the link store's registered read.
//
// Reset: all stacks empty, the store free. After reset release the link
// store is rebuilt as a chain, one entry a cycle, with busy high throughout.
`default_nettype none
module shared_buffer_multi_stack #(
	parameter int DEPTH      = 64,
	parameter int NUM_STACKS = 4,
	parameter int DATA_WIDTH = 32,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [1:0]                   stack_id,
	input  logic signed [DATA_WIDTH-1:0] push_value,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] pop_value,
	output logic [1:0]                   status,
	output logic [CW-1:0]                entries_used
);
	import sbms_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

	state_t state_q, state_d;

	logic [AW-1:0] init_cnt_q;
	logic [AW-1:0] stack_top_q [NUM_STACKS];
	logic          stack_empty_q [NUM_STACKS];
	logic [AW-1:0] free_head_q;
	logic [CW-1:0] used_q;

	logic                  op_q;
	logic [SW-1:0]         sid_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [AW-1:0]         slot_q;
	logic [1:0]            st_q;

	logic                  done_q;
	logic [DATA_WIDTH-1:0] pop_value_q;
	logic [1:0]            status_q;
	logic [CW-1:0]         entries_used_q;

	logic                  accept;
	logic                  sid_ok;
	logic [SW-1:0]         sid;
	logic [1:0]            acc_status;
	logic [AW-1:0]         rd_addr;
	logic                  exec_ok;
	logic                  link_we;
	logic [AW-1:0]         link_waddr;
	logic [AW-1:0]         link_wdata;
	logic [AW-1:0]         link_rd;
	logic                  val_we;
	logic [DATA_WIDTH-1:0] val_rd;
	logic [CW-1:0]         used_next;

	assign accept = start && (state_q == ST_IDLE);
	assign sid_ok = 32'(stack_id) < NUM_STACKS;
	assign sid    = SW'(stack_id);

	always_comb begin
		if (req_type == REQ_PUSH) begin
			acc_status = (!sid_ok || used_q >= CW'(DEPTH)) ? STATUS_FULL : STATUS_OK;
			rd_addr    = free_head_q;
		end else begin
			acc_status = (!sid_ok || stack_empty_q[sid]) ? STATUS_EMPTY : STATUS_OK;
			rd_addr    = sid_ok ? stack_top_q[sid] : free_head_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (init_cnt_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (start) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			init_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) begin
				init_cnt_q <= init_cnt_q + AW'(1);
			end
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign exec_ok = (state_q == ST_EXEC) && (st_q == STATUS_OK);

	// link store: chain fill after reset, then one write-back per successful request
	always_comb begin
		if (state_q == ST_INIT) begin
			link_we    = 1'b1;
			link_waddr = init_cnt_q;
			link_wdata = (init_cnt_q == AW'(DEPTH - 1)) ? '0 : init_cnt_q + AW'(1);
		end else begin
			link_we    = exec_ok;
			link_waddr = slot_q;
			if (op_q == REQ_POP) begin
				link_wdata = free_head_q;
			end else begin
				link_wdata = stack_empty_q[sid_q] ? '0 : stack_top_q[sid_q];
			end
		end
	end

	assign val_we = exec_ok && (op_q == REQ_PUSH);

	sbms_ram #(.W(AW), .N(DEPTH)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	sbms_ram #(.W(DATA_WIDTH), .N(DEPTH)) u_value (
		.clk   (clk),
		.we    (val_we),
		.waddr (slot_q),
		.wdata (val_q),
		.raddr (rd_addr),
		.rdata (val_rd)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req_type;
			sid_q  <= sid;
			val_q  <= push_value;
			slot_q <= rd_addr;
			st_q   <= acc_status;
		end
	end

	always_comb begin
		used_next = used_q;
		if (exec_ok) begin
			if (op_q == REQ_PUSH) begin
				used_next = used_q + CW'(1);
			end else if (used_q != '0) begin
				used_next = used_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				stack_top_q[i]   <= '0;
				stack_empty_q[i] <= 1'b1;
			end
			free_head_q <= '0;
			used_q      <= '0;
		end else begin
			used_q <= used_next;
			if (exec_ok) begin
				if (op_q == REQ_PUSH) begin
					free_head_q          <= link_rd;
					stack_top_q[sid_q]   <= slot_q;
					stack_empty_q[sid_q] <= 1'b0;
				end else begin
					stack_top_q[sid_q] <= link_rd;
					free_head_q        <= slot_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			pop_value_q    <= (exec_ok && op_q == REQ_POP) ? val_rd : '0;
			status_q       <= st_q;
			entries_used_q <= used_next;
		end
	end

	assign done         = done_q;
	assign pop_value    = pop_value_q;
	assign status       = status_q;
	assign entries_used = entries_used_q;

endmodule
`default_nettype wire

/* hdl/sbms_ram.sv */
`default_nettype none
module sbms_ram #(
	parameter int W = 32,
	parameter int N = 64,
	localparam int AW = (N > 1) ? $clog2(N) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [N];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* hdl/sbms_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module sbms_checker #(
	parameter int DATA_WIDTH = 32
) (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  start,
	input wire                  busy,
	input wire                  done,
	input wire [DATA_WIDTH-1:0] pop_value,
	input wire [1:0]            status
);
	import sbms_pkg::*;

	`ASSERT_CLK(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "busy not raised after transfer")
	`ASSERT_CLK(a_accept_done, clk, arst_n, (start && !busy) |-> ##2 done, "result missing two cycles after transfer")
	`ASSERT_CLK(a_done_single, clk, arst_n, done |=> !done, "back-to-back result strobes")
	`ASSERT_CLK(a_status_code, clk, arst_n, done |-> (status == STATUS_OK || status == STATUS_FULL || status == STATUS_EMPTY), "bad status code")
	`ASSERT_NEVER(a_refused_zero, clk, arst_n, done && status != STATUS_OK && pop_value != '0, "refused request returned data")

endmodule

bind shared_buffer_multi_stack sbms_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sbms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.pop_value (pop_value),
	.status    (status)
);
`default_nettype wire
